// File: design/tcc_pkg.sv
// Shared constants, codes and beat types for the text console cursor engine.
`timescale 1ns / 1ps
`default_nettype none
package tcc_pkg;

    localparam int DEF_COLUMNS  = 80;
    localparam int DEF_ROWS     = 25;
    localparam int DEF_TAB_STOP = 8;

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 11;
    localparam int DATA_W = 16;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int OFS_W  = 11;
    localparam int ATTR_W = 8;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS         = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_LAST = 8'h7F;

    localparam logic [DATA_W-1:0] BLANK_CELL = 16'h0020;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CHAR_W-1:0] char_code;
        logic [ADDR_W-1:0] cell_address;
    } t_in_beat;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic [OFS_W-1:0]  cursor_linear;
    } t_out_beat;

endpackage
`default_nettype wire

// File: design/tcc_in_if.sv
// Command channel carrying one console operation per beat.
`timescale 1ns / 1ps
`default_nettype none
interface tcc_in_if;
    import tcc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/tcc_out_if.sv
// Response channel carrying one cursor report per beat.
`timescale 1ns / 1ps
`default_nettype none
interface tcc_out_if;
    import tcc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/tcc_alu.sv
// Shared add/subtract and compare unit used by the sequencer's divide, tab, address, fill and offset steps.
`timescale 1ns / 1ps
`default_nettype none
module tcc_alu #(
    parameter int W = 12
) (
    input  wire logic         i_op,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic      [W-1:0] o_res,
    output logic              o_ge
);
    import tcc_pkg::*;

    assign o_res = (i_op == ALU_SUB) ? (i_a - i_b) : (i_a + i_b);
    assign o_ge  = (i_a >= i_b);
endmodule
`default_nettype wire

// File: design/tcc_cell_ram.sv
// Single-port cell store with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tcc_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_addr,
    input  wire logic [tcc_pkg::DATA_W-1:0] i_wdata,
    output logic      [tcc_pkg::DATA_W-1:0] o_rdata
);
    import tcc_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: design/tcc_seq.sv
// Sequencer: cursor, row base rotation, row valid bits and cell access steps.
`timescale 1ns / 1ps
`default_nettype none
module tcc_seq #(
    parameter int COLUMNS  = tcc_pkg::DEF_COLUMNS,
    parameter int ROWS     = tcc_pkg::DEF_ROWS,
    parameter int TAB_STOP = tcc_pkg::DEF_TAB_STOP,
    parameter int CELL_AW  = 11,
    parameter int ALU_W    = 12
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [tcc_pkg::ATTR_W-1:0] i_cfg_data,
    tcc_in_if.sink                          i_cmd,
    tcc_out_if.source                       o_rsp,
    output logic                            o_ram_we,
    output logic      [CELL_AW-1:0]         o_ram_addr,
    output logic      [tcc_pkg::DATA_W-1:0] o_ram_wdata,
    input  wire logic [tcc_pkg::DATA_W-1:0] i_ram_rdata,
    output logic                            o_alu_op,
    output logic      [ALU_W-1:0]           o_alu_a,
    output logic      [ALU_W-1:0]           o_alu_b,
    input  wire logic [ALU_W-1:0]           i_alu_res,
    input  wire logic                       i_alu_ge
);
    import tcc_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int CW2   = $clog2(COLUMNS + TAB_STOP);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int PRW   = $clog2(ROWS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIV    = 4'd1;
    localparam logic [3:0] S_PROW   = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_ADDR   = 4'd4;
    localparam logic [3:0] S_FILL   = 4'd5;
    localparam logic [3:0] S_WRITE  = 4'd6;
    localparam logic [3:0] S_RDREQ  = 4'd7;
    localparam logic [3:0] S_RDWAIT = 4'd8;
    localparam logic [3:0] S_TAB    = 4'd9;
    localparam logic [3:0] S_COLCHK = 4'd10;
    localparam logic [3:0] S_ROWCHK = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;
    localparam logic [3:0] S_OFS    = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    logic [3:0]        r_state;
    logic [CW2-1:0]    r_col;
    logic [RW-1:0]     r_row;
    logic [PRW-1:0]    r_base;
    logic [ROWS-1:0]   r_valid;
    logic [ATTR_W-1:0] r_attr;

    logic [OP_W-1:0]   r_op;
    logic [CHAR_W-1:0] r_ch;
    logic [ALU_W-1:0]  r_rem;
    logic [RW-1:0]     r_q;
    logic [RW-1:0]     r_lrow;
    logic [CW2-1:0]    r_lcol;
    logic [PRW-1:0]    r_prow;
    logic [CELL_AW-1:0] r_prod;
    logic [CELL_AW-1:0] r_paddr;
    logic [CW-1:0]     r_fill;
    logic [DATA_W-1:0] r_rd;
    logic [OFS_W-1:0]  r_ofs;

    logic [PRW:0]      prow_sum;
    logic [RW-1:0]     mul_in;
    logic              printable;

    assign prow_sum  = (PRW+1)'(r_base) + (PRW+1)'(r_lrow[PRW-1:0]);
    assign mul_in    = (r_state == S_MUL) ? RW'(r_prow) : r_row;
    assign printable = (i_cmd.payload.char_code >= CH_SPACE) &&
                       (i_cmd.payload.char_code <= CH_PRINT_LAST);

    always_comb begin
        o_alu_op = ALU_ADD;
        o_alu_a  = r_rem;
        o_alu_b  = '0;
        unique case (r_state)
            S_DIV: begin
                o_alu_op = ALU_SUB;
                o_alu_b  = ALU_W'(COLUMNS);
            end
            S_TAB: begin
                o_alu_b = ALU_W'(TAB_STOP);
            end
            S_ADDR: begin
                o_alu_a = ALU_W'(r_prod);
                o_alu_b = ALU_W'(r_lcol);
            end
            S_FILL: begin
                o_alu_a = ALU_W'(r_prod);
                o_alu_b = ALU_W'(r_fill);
            end
            S_OFS: begin
                o_alu_a = ALU_W'(r_prod);
                o_alu_b = ALU_W'(r_col);
            end
            default: begin
                o_alu_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_base  <= '0;
            r_valid <= '0;
            r_attr  <= ATTR_RESET;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_op   <= i_cmd.payload.operation;
                        r_ch   <= i_cmd.payload.char_code;
                        r_rd   <= '0;
                        r_q    <= '0;
                        r_lrow <= r_row;
                        r_lcol <= r_col;
                        unique case (i_cmd.payload.operation)
                            OP_PUT: begin
                                case (i_cmd.payload.char_code)
                                    CH_BS: begin
                                        if (r_col != '0) begin
                                            r_col <= r_col - 1'b1;
                                        end
                                        r_state <= S_DONE;
                                    end
                                    CH_TAB: begin
                                        r_rem   <= ALU_W'(TAB_STOP);
                                        r_state <= S_TAB;
                                    end
                                    CH_CR: begin
                                        r_col   <= '0;
                                        r_state <= S_DONE;
                                    end
                                    CH_LF: begin
                                        r_col   <= '0;
                                        r_row   <= r_row + 1'b1;
                                        r_state <= S_ROWCHK;
                                    end
                                    default: begin
                                        r_state <= printable ? S_PROW : S_DONE;
                                    end
                                endcase
                            end
                            OP_CLEAR: begin
                                r_valid <= '0;
                                r_col   <= '0;
                                r_row   <= '0;
                                r_state <= S_DONE;
                            end
                            OP_READ: begin
                                r_rem <= ALU_W'(i_cmd.payload.cell_address);
                                if (ALU_W'(i_cmd.payload.cell_address) >= ALU_W'(CELLS)) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (i_alu_ge) begin
                        r_rem <= i_alu_res;
                        r_q   <= r_q + 1'b1;
                    end else begin
                        r_lrow  <= r_q;
                        r_lcol  <= CW2'(r_rem);
                        r_state <= S_PROW;
                    end
                end
                S_PROW: begin
                    r_prow  <= (prow_sum >= (PRW+1)'(ROWS)) ?
                               PRW'(prow_sum - (PRW+1)'(ROWS)) : PRW'(prow_sum);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= CELL_AW'(mul_in * COLUMNS);
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    r_paddr <= i_alu_res[CELL_AW-1:0];
                    r_fill  <= '0;
                    if (r_op == OP_READ) begin
                        if (r_valid[r_prow]) begin
                            r_state <= S_RDREQ;
                        end else begin
                            r_rd    <= BLANK_CELL;
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= r_valid[r_prow] ? S_WRITE : S_FILL;
                    end
                end
                S_FILL: begin
                    if (r_fill == CW'(COLUMNS - 1)) begin
                        r_valid[r_prow] <= 1'b1;
                        r_state         <= S_WRITE;
                    end else begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                S_WRITE: begin
                    r_col   <= r_col + 1'b1;
                    r_state <= S_COLCHK;
                end
                S_RDREQ: begin
                    r_state <= S_RDWAIT;
                end
                S_RDWAIT: begin
                    r_rd    <= i_ram_rdata;
                    r_state <= S_DONE;
                end
                S_TAB: begin
                    if (r_rem > ALU_W'(r_col)) begin
                        r_col   <= CW2'(r_rem);
                        r_state <= S_COLCHK;
                    end else begin
                        r_rem <= i_alu_res;
                    end
                end
                S_COLCHK: begin
                    if (r_col >= CW2'(COLUMNS)) begin
                        r_col   <= '0;
                        r_row   <= r_row + 1'b1;
                        r_state <= S_ROWCHK;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_ROWCHK: begin
                    if (r_row >= RW'(ROWS)) begin
                        r_row           <= RW'(ROWS - 1);
                        r_valid[r_base] <= 1'b0;
                        r_base          <= (r_base == PRW'(ROWS - 1)) ? '0 : r_base + 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_prod  <= CELL_AW'(mul_in * COLUMNS);
                    r_state <= S_OFS;
                end
                S_OFS: begin
                    r_ofs   <= i_alu_res[OFS_W-1:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ram_we    = (r_state == S_FILL) || (r_state == S_WRITE);
    assign o_ram_addr  = (r_state == S_FILL) ? i_alu_res[CELL_AW-1:0] : r_paddr;
    assign o_ram_wdata = (r_state == S_FILL) ? BLANK_CELL : {r_attr, r_ch};

    assign i_cmd.ready                 = (r_state == S_IDLE);
    assign o_rsp.valid                 = (r_state == S_OUT);
    assign o_rsp.payload.read_data     = r_rd;
    assign o_rsp.payload.cursor_column = COL_W'(r_col);
    assign o_rsp.payload.cursor_row    = ROW_W'(r_row);
    assign o_rsp.payload.cursor_linear = r_ofs;
endmodule
`default_nettype wire

// File: design/text_console_cursor_engine_top.sv
// Top level of the character-cell text console with cursor tracking.
//
// i_cmd takes one beat per operation: put character, clear screen or read
// one cell. o_rsp returns exactly one beat per command with the cell read
// (zero unless a read) and the cursor column, row and linear position after
// the command. i_cfg_we/i_cfg_data load the attribute byte for new cells.
// One command is in flight at a time; i_cmd.ready is high only while idle.
// Tab and in-range read commands loop through the shared add/compare unit,
// stepping one column count or tab stop per cycle; a printable byte first
// works out the physical row and cell address, then writes the cell.
// A put into a row not written since reset, clear or scroll first blanks
// that row, one cell a cycle through the single store port.
// i_cmd.ready returns the cycle after the response is taken.
// Scrolling rotates a row base and marks the recycled row blank at once.
// Reset homes the cursor and marks every row blank; no sweep is needed.
// A stalled response holds its beat and no further command is taken.
`timescale 1ns / 1ps
`default_nettype none
module text_console_cursor_engine_top #(
    parameter int COLUMNS  = tcc_pkg::DEF_COLUMNS,
    parameter int ROWS     = tcc_pkg::DEF_ROWS,
    parameter int TAB_STOP = tcc_pkg::DEF_TAB_STOP
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [tcc_pkg::ATTR_W-1:0] i_cfg_data,
    tcc_in_if.sink                          i_cmd,
    tcc_out_if.source                       o_rsp
);
    import tcc_pkg::*;

    localparam int CELLS   = ROWS * COLUMNS;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int ALU_W   = ((CELL_AW > ADDR_W) ? CELL_AW : ADDR_W) + 1;

    logic               ram_we;
    logic [CELL_AW-1:0] ram_addr;
    logic [DATA_W-1:0]  ram_wdata;
    logic [DATA_W-1:0]  ram_rdata;
    logic               alu_op;
    logic [ALU_W-1:0]   alu_a;
    logic [ALU_W-1:0]   alu_b;
    logic [ALU_W-1:0]   alu_res;
    logic               alu_ge;

    tcc_seq #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP),
        .CELL_AW  (CELL_AW),
        .ALU_W    (ALU_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (i_cmd),
        .o_rsp       (o_rsp),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata),
        .o_alu_op    (alu_op),
        .o_alu_a     (alu_a),
        .o_alu_b     (alu_b),
        .i_alu_res   (alu_res),
        .i_alu_ge    (alu_ge)
    );

    tcc_alu #(
        .W (ALU_W)
    ) u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res),
        .o_ge  (alu_ge)
    );

    tcc_cell_ram #(
        .DEPTH (CELLS),
        .AW    (CELL_AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );
endmodule
`default_nettype wire

// File: design/tcc_checker.sv
// Port-level checks for the text console, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tcc_checker #(
    parameter int COLUMNS = tcc_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcc_pkg::DEF_ROWS
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire tcc_pkg::t_out_beat i_out_beat
);
    import tcc_pkg::*;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("command taken while a response is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready held after a command beat");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((32'(i_out_beat.cursor_column) < COLUMNS) &&
                         (32'(i_out_beat.cursor_row) < ROWS)))
        else $error("cursor outside the screen");

    a_offset_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_beat.cursor_linear ==
            OFS_W'(32'(i_out_beat.cursor_row) * COLUMNS + 32'(i_out_beat.cursor_column))))
        else $error("linear cursor position disagrees with row and column");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_beat)))
        else $error("stalled response beat changed");
endmodule

bind text_console_cursor_engine_top tcc_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_beat  (o_rsp.payload)
);
`default_nettype wire
